// File: hdl/chs_pkg.sv
// Shared types and codes of the cellar hash set.
`timescale 1ns / 1ps

package chs_pkg;

  localparam int unsigned KEY_W       = 16;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned MARK_W      = 2;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Request codes; the spare code behaves as a lookup.
  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND      = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_INSERTED   = 3'd2,
    ST_PRESENT    = 3'd3,
    ST_FULL       = 3'd4,
    ST_DELETED    = 3'd5,
    ST_DEL_MISSED = 3'd6
  } status_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_WALK,
    BK_FREE,
    BK_LINK,
    BK_DEL
  } back_state_e;

  // Request as it travels from the hash front to the table back end.
  typedef struct packed {
    req_e             req;
    logic [KEY_W-1:0] key;
  } req_t;

endpackage

// File: hdl/chs_front.sv
// Front end: takes requests and computes the home slot over three stages.
`timescale 1ns / 1ps

module chs_front #(
  parameter int unsigned PRIME_SLOTS = 12,
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned HOME_W      = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic [chs_pkg::REQ_W-1:0]     req_type_i,
  input  logic [chs_pkg::KEY_W-1:0]     key_i,
  output logic                          push_o,
  output chs_pkg::req_t                 push_req_o,
  output logic [HOME_W-1:0]             push_home_o,
  output logic [1:0]                    inflight_o
);

  localparam int unsigned KW      = chs_pkg::KEY_W;
  localparam int unsigned SHIFT   = KW + $clog2(PRIME_SLOTS);
  localparam logic [63:0] RECIP   = (64'd1 << SHIFT) / PRIME_SLOTS;
  localparam int unsigned MW      = $clog2(RECIP + 64'd1);
  localparam int unsigned PROD_W  = KW + MW;
  localparam int unsigned PW      = $clog2(PRIME_SLOTS + 1);
  localparam int unsigned QP_W    = KW + PW;
  localparam logic [KW-1:0] KEY_MASK =
    (KEY_BITS >= KW) ? {KW{1'b1}} : KW'((64'd1 << KEY_BITS) - 64'd1);

  logic                v1_q, v2_q, v3_q;
  chs_pkg::req_t       r1_q, r2_q, r3_q;
  logic [PROD_W-1:0]   prod2_q;
  logic [QP_W-1:0]     qp3_q;
  logic [PROD_W-1:0]   prod_d;
  logic [KW-1:0]       quot;
  logic [QP_W-1:0]     qp_d;
  logic [KW-1:0]       rem;
  logic [KW-1:0]       home;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= take_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Reciprocal multiply gives a quotient that is exact or one short.
  assign prod_d = PROD_W'(r1_q.key) * PROD_W'(RECIP[MW-1:0]);
  assign quot   = KW'(prod2_q >> SHIFT);
  assign qp_d   = QP_W'(quot) * QP_W'(PRIME_SLOTS);

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      r1_q.req <= chs_pkg::req_e'(req_type_i);
      r1_q.key <= key_i & KEY_MASK;
    end
    r2_q    <= r1_q;
    prod2_q <= prod_d;
    r3_q    <= r2_q;
    qp3_q   <= qp_d;
  end

  // Remainder stays below twice the divisor: one correction step.
  assign rem  = r3_q.key - qp3_q[KW-1:0];
  assign home = (rem >= KW'(PRIME_SLOTS)) ? rem - KW'(PRIME_SLOTS) : rem;

  assign push_o      = v3_q;
  assign push_req_o  = r3_q;
  assign push_home_o = home[HOME_W-1:0];
  assign inflight_o  = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);

endmodule

// File: hdl/chs_fifo.sv
// Short request queue between the hash front and the table back end.
`timescale 1ns / 1ps

module chs_fifo #(
  parameter int unsigned DATA_W = 24,
  parameter int unsigned DEPTH  = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [DATA_W-1:0]            push_data_i,
  input  logic                         pop_i,
  output logic [DATA_W-1:0]            pop_data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   level_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0]  level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + 1'b1;
      end else if (pop_i && !push_i) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign empty_o    = (level_q == '0);
  assign level_o    = level_q;

endmodule

// File: hdl/chs_back.sv
// Back end: slot memories, free list and the chain-walking sequencer.
`timescale 1ns / 1ps

module chs_back #(
  parameter int unsigned TOTAL_SLOTS = 16,
  parameter int unsigned PRIME_SLOTS = 12,
  parameter int unsigned LINK_W      = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  chs_pkg::req_t                  q_req_i,
  input  logic [LINK_W-1:0]              q_home_i,
  output logic                           q_pop_o,
  output logic                           clearing_o,
  output logic                           done_o,
  output logic [chs_pkg::STATUS_W-1:0]   status_o
);

  localparam int unsigned IDX_W  = $clog2(TOTAL_SLOTS);
  localparam int unsigned KW     = chs_pkg::KEY_W;
  localparam int unsigned META_W = chs_pkg::MARK_W + LINK_W;
  localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(TOTAL_SLOTS);
  localparam logic [LINK_W-1:0] PRIME_LINK = LINK_W'(PRIME_SLOTS);
  localparam logic [LINK_W-1:0] FREE_RESET =
    (PRIME_SLOTS < TOTAL_SLOTS) ? LINK_W'(PRIME_SLOTS) : LINK_W'(TOTAL_SLOTS);

  logic [KW-1:0]     key_mem  [TOTAL_SLOTS];
  logic [META_W-1:0] meta_mem [TOTAL_SLOTS];

  chs_pkg::back_state_e state_q, state_d;
  chs_pkg::req_e        req_q, req_d;
  logic [KW-1:0]        key_q, key_d;
  logic [LINK_W-1:0]    home_q, home_d;
  logic [LINK_W-1:0]    idx_q, idx_d;
  logic [LINK_W-1:0]    step_q, step_d;
  logic [LINK_W-1:0]    prev_q, prev_d;
  chs_pkg::mark_e       prev_mark_q, prev_mark_d;
  chs_pkg::mark_e       home_mark_q, home_mark_d;
  logic [LINK_W-1:0]    home_next_q, home_next_d;
  logic [LINK_W-1:0]    link_q, link_d;
  logic [LINK_W-1:0]    clr_q, clr_d;
  logic [LINK_W-1:0]    free_head_q, free_head_d;
  logic                 done_q, done_d;
  chs_pkg::status_e     status_q, status_d;

  logic                 rd_en;
  logic [LINK_W-1:0]    rd_addr;
  logic [KW-1:0]        rd_key_q;
  chs_pkg::mark_e       rd_mark_q;
  logic [LINK_W-1:0]    rd_next_q;

  logic                 wr_meta, wr_key;
  logic [LINK_W-1:0]    wr_addr;
  chs_pkg::mark_e       wr_mark;
  logic [LINK_W-1:0]    wr_next;

  logic                 hit, first, last_step, next_null, is_lookup;
  chs_pkg::mark_e       cur_home_mark;
  logic [LINK_W-1:0]    cur_home_next;

  always_ff @(posedge clk_i) begin
    if (wr_meta) begin
      meta_mem[wr_addr[IDX_W-1:0]] <= {wr_mark, wr_next};
    end
    if (wr_key) begin
      key_mem[wr_addr[IDX_W-1:0]] <= key_q;
    end
    if (rd_en) begin
      rd_key_q  <= key_mem[rd_addr[IDX_W-1:0]];
      rd_mark_q <= chs_pkg::mark_e'(meta_mem[rd_addr[IDX_W-1:0]][META_W-1:LINK_W]);
      rd_next_q <= meta_mem[rd_addr[IDX_W-1:0]][LINK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chs_pkg::BK_CLEAR;
      clr_q       <= '0;
      free_head_q <= FREE_RESET;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_head_q <= free_head_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    key_q       <= key_d;
    home_q      <= home_d;
    idx_q       <= idx_d;
    step_q      <= step_d;
    prev_q      <= prev_d;
    prev_mark_q <= prev_mark_d;
    home_mark_q <= home_mark_d;
    home_next_q <= home_next_d;
    link_q      <= link_d;
    status_q    <= status_d;
  end

  assign hit       = (rd_mark_q == chs_pkg::MARK_USED) && (rd_key_q == key_q);
  assign first     = (step_q == '0);
  assign last_step = (step_q == NULL_LINK);
  assign next_null = (rd_next_q >= NULL_LINK);
  assign is_lookup = (req_q != chs_pkg::REQ_INSERT) && (req_q != chs_pkg::REQ_DELETE);
  assign cur_home_mark = first ? rd_mark_q : home_mark_q;
  assign cur_home_next = first ? rd_next_q : home_next_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    key_d       = key_q;
    home_d      = home_q;
    idx_d       = idx_q;
    step_d      = step_q;
    prev_d      = prev_q;
    prev_mark_d = prev_mark_q;
    home_mark_d = home_mark_q;
    home_next_d = home_next_q;
    link_d      = link_q;
    clr_d       = clr_q;
    free_head_d = free_head_q;
    done_d      = 1'b0;
    status_d    = status_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_meta     = 1'b0;
    wr_key      = 1'b0;
    wr_addr     = '0;
    wr_mark     = chs_pkg::MARK_EMPTY;
    wr_next     = NULL_LINK;

    unique case (state_q)
      chs_pkg::BK_CLEAR: begin
        // Restore marks and links: prime slots null, overflow slots chained.
        wr_meta = 1'b1;
        wr_addr = clr_q;
        wr_next = (clr_q < PRIME_LINK || clr_q + 1'b1 >= NULL_LINK) ? NULL_LINK
                                                                    : clr_q + 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == NULL_LINK - 1'b1) begin
          state_d = chs_pkg::BK_IDLE;
        end
      end

      chs_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          req_d   = q_req_i.req;
          key_d   = q_req_i.key;
          home_d  = q_home_i;
          if (q_home_i >= NULL_LINK) begin
            done_d = 1'b1;
            unique case (q_req_i.req)
              chs_pkg::REQ_INSERT: status_d = chs_pkg::ST_FULL;
              chs_pkg::REQ_DELETE: status_d = chs_pkg::ST_DEL_MISSED;
              default:             status_d = chs_pkg::ST_NOT_FOUND;
            endcase
          end else begin
            rd_en   = 1'b1;
            rd_addr = q_home_i;
            idx_d   = q_home_i;
            step_d  = '0;
            state_d = chs_pkg::BK_WALK;
          end
        end
      end

      chs_pkg::BK_WALK: begin
        if (first) begin
          home_mark_d = rd_mark_q;
          home_next_d = rd_next_q;
        end
        if (req_q == chs_pkg::REQ_DELETE) begin
          if (hit && first) begin
            wr_meta  = 1'b1;
            wr_addr  = idx_q;
            wr_mark  = chs_pkg::MARK_DELETED;
            wr_next  = rd_next_q;
            done_d   = 1'b1;
            status_d = chs_pkg::ST_DELETED;
            state_d  = chs_pkg::BK_IDLE;
          end else if (hit) begin
            // Return the node to the free list; relink its predecessor next.
            wr_meta     = 1'b1;
            wr_addr     = idx_q;
            wr_mark     = chs_pkg::MARK_EMPTY;
            wr_next     = free_head_q;
            free_head_d = idx_q;
            link_d      = rd_next_q;
            state_d     = chs_pkg::BK_DEL;
          end else begin
            prev_d      = idx_q;
            prev_mark_d = rd_mark_q;
            if (last_step || next_null) begin
              done_d   = 1'b1;
              status_d = chs_pkg::ST_DEL_MISSED;
              state_d  = chs_pkg::BK_IDLE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = rd_next_q;
              idx_d   = rd_next_q;
              step_d  = step_q + 1'b1;
            end
          end
        end else begin
          if (hit) begin
            done_d   = 1'b1;
            status_d = is_lookup ? chs_pkg::ST_FOUND : chs_pkg::ST_PRESENT;
            state_d  = chs_pkg::BK_IDLE;
          end else if (rd_mark_q != chs_pkg::MARK_EMPTY && !last_step && !next_null) begin
            rd_en   = 1'b1;
            rd_addr = rd_next_q;
            idx_d   = rd_next_q;
            step_d  = step_q + 1'b1;
          end else if (is_lookup) begin
            done_d   = 1'b1;
            status_d = chs_pkg::ST_NOT_FOUND;
            state_d  = chs_pkg::BK_IDLE;
          end else if (cur_home_mark != chs_pkg::MARK_USED) begin
            // Reuse an empty or deleted home slot; its chain stays.
            wr_meta  = 1'b1;
            wr_key   = 1'b1;
            wr_addr  = home_q;
            wr_mark  = chs_pkg::MARK_USED;
            wr_next  = cur_home_next;
            done_d   = 1'b1;
            status_d = chs_pkg::ST_INSERTED;
            state_d  = chs_pkg::BK_IDLE;
          end else if (free_head_q >= NULL_LINK) begin
            done_d   = 1'b1;
            status_d = chs_pkg::ST_FULL;
            state_d  = chs_pkg::BK_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = free_head_q;
            idx_d   = free_head_q;
            state_d = chs_pkg::BK_FREE;
          end
        end
      end

      chs_pkg::BK_FREE: begin
        // Pop the node and splice it in right after the home slot.
        free_head_d = rd_next_q;
        wr_meta     = 1'b1;
        wr_key      = 1'b1;
        wr_addr     = idx_q;
        wr_mark     = chs_pkg::MARK_USED;
        wr_next     = home_next_q;
        state_d     = chs_pkg::BK_LINK;
      end

      chs_pkg::BK_LINK: begin
        wr_meta  = 1'b1;
        wr_addr  = home_q;
        wr_mark  = home_mark_q;
        wr_next  = idx_q;
        done_d   = 1'b1;
        status_d = chs_pkg::ST_INSERTED;
        state_d  = chs_pkg::BK_IDLE;
      end

      chs_pkg::BK_DEL: begin
        wr_meta  = 1'b1;
        wr_addr  = prev_q;
        wr_mark  = prev_mark_q;
        wr_next  = link_q;
        done_d   = 1'b1;
        status_d = chs_pkg::ST_DELETED;
        state_d  = chs_pkg::BK_IDLE;
      end

      default: begin
        state_d = chs_pkg::BK_IDLE;
      end
    endcase
  end

  assign clearing_o = (state_q == chs_pkg::BK_CLEAR);
  assign done_o     = done_q;
  assign status_o   = status_q;

endmodule

// File: hdl/cellar_hash_set.sv
// Top level of the cellar hash set: hash front, request queue, table back end.
`timescale 1ns / 1ps

// Hash set of keys with a prime area of PRIME_SLOTS home slots (home = key
// mod PRIME_SLOTS) and an overflow area of TOTAL_SLOTS - PRIME_SLOTS chain
// nodes kept on a free list. Issue a request by raising start_i while busy_o
// is low; req_type_i selects lookup (0, and the spare code 3), insert (1) or
// delete (2). Every request gives exactly one status on status_o, marked by a
// one-cycle done_o pulse, in request order. The receiver cannot hold results
// off: sample status_o whenever done_o is high. The front computes the home
// slot by reciprocal multiplication in registered stages, then the request
// waits in a four-entry queue. The back end pops it and reads the home slot,
// then reads each slot visited on the chain in turn through the single read
// port of the slot memory, and ends an insert into the overflow area or a
// chain delete with further writes. It works on one request at a time. After
// reset the back end runs a clearing pass over the slot memory, during which
// busy_o stays high. PRIME_SLOTS must not exceed TOTAL_SLOTS; keys are masked
// to KEY_BITS bits.

module cellar_hash_set #(
  parameter int unsigned TOTAL_SLOTS = 16,
  parameter int unsigned PRIME_SLOTS = 12,
  parameter int unsigned KEY_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [chs_pkg::REQ_W-1:0]     req_type_i,
  input  logic [chs_pkg::KEY_W-1:0]     key_i,
  output logic                          done_o,
  output logic [chs_pkg::STATUS_W-1:0]  status_o
);

  // Link width holds every slot index plus the null link (TOTAL_SLOTS).
  localparam int unsigned LINK_W = $clog2(TOTAL_SLOTS + 1);
  localparam int unsigned ENTRY_W = LINK_W + $bits(chs_pkg::req_t);
  localparam int unsigned DEPTH  = chs_pkg::QUEUE_DEPTH;
  localparam int unsigned LVL_W  = $clog2(DEPTH + 1);

  logic                take;
  logic                push;
  chs_pkg::req_t       push_req;
  logic [LINK_W-1:0]   push_home;
  logic [1:0]          inflight;
  logic [ENTRY_W-1:0]  pop_data;
  logic                q_empty;
  logic [LVL_W-1:0]    q_level;
  logic                q_pop;
  logic                clearing;
  logic [LVL_W:0]      occupancy;

  // Accept a request only when the queue has room for everything in flight.
  assign occupancy = (LVL_W + 1)'(q_level) + (LVL_W + 1)'(inflight);
  assign busy_o    = clearing || (occupancy >= (LVL_W + 1)'(DEPTH));
  assign take      = start_i && !busy_o;

  chs_front #(
    .PRIME_SLOTS (PRIME_SLOTS),
    .KEY_BITS    (KEY_BITS),
    .HOME_W      (LINK_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .push_o      (push),
    .push_req_o  (push_req),
    .push_home_o (push_home),
    .inflight_o  (inflight)
  );

  chs_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_home, push_req}),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty),
    .level_o     (q_level)
  );

  chs_back #(
    .TOTAL_SLOTS (TOTAL_SLOTS),
    .PRIME_SLOTS (PRIME_SLOTS),
    .LINK_W      (LINK_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_req_i    (chs_pkg::req_t'(pop_data[$bits(chs_pkg::req_t)-1:0])),
    .q_home_i   (pop_data[ENTRY_W-1:$bits(chs_pkg::req_t)]),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .status_o   (status_o)
  );

endmodule
